// ===== src/snils_check_digit_validator_unit_macros.svh =====
// Assertion macros for the identifier check-digit validator.
// Plain text only; used by the top level at the end of its body.
`ifndef SNILS_CHECK_DIGIT_VALIDATOR_UNIT_MACROS_SVH
`define SNILS_CHECK_DIGIT_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SCDV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SCDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/scdv_pkg.sv =====
// Shared constants, status codes and the check-number reduction
// for the identifier check-digit validator. No dependencies.
package scdv_pkg;

  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_FORMAT   = 2'd2
  } status_t;

  localparam logic [3:0] SNILS_DIGITS = 4'd11;
  localparam logic [3:0] SUM_DIGITS   = 4'd9;
  localparam logic [3:0] COUNT_SAT    = 4'd12;
  localparam logic [3:0] REPEAT_MIN   = 4'd2;

  localparam logic [8:0] CHECK_LIMIT  = 9'd100;
  localparam logic [8:0] CHECK_MOD    = 9'd101;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Reduce a 9-bit weighted sum to the two-digit check number.
  // The sum is below 512, so at most five multiples of the modulus apply.
  function automatic logic [6:0] check_number(input logic [8:0] sum);
    logic [8:0] rem;
    rem = sum;
    if (sum < CHECK_LIMIT) begin
      rem = sum;
    end else if (sum == CHECK_LIMIT || sum == CHECK_MOD) begin
      rem = '0;
    end else begin
      priority if (sum >= 9'(5 * 101)) begin
        rem = sum - 9'(5 * 101);
      end else if (sum >= 9'(4 * 101)) begin
        rem = sum - 9'(4 * 101);
      end else if (sum >= 9'(3 * 101)) begin
        rem = sum - 9'(3 * 101);
      end else if (sum >= 9'(2 * 101)) begin
        rem = sum - 9'(2 * 101);
      end else begin
        rem = sum - CHECK_MOD;
      end
      if (rem == CHECK_LIMIT) begin
        rem = '0;
      end
    end
    return rem[6:0];
  endfunction

endpackage

// ===== src/snils_check_digit_validator_unit.sv =====
// Top level of the identifier check-digit validator: input register,
// per-character digit logic and result register. Uses scdv_pkg and the
// assertion macros in snils_check_digit_validator_unit_macros.svh.
//
//   Channel  Direction  Word contents
//   -------  ---------  ---------------------------------------------------
//   in_      slave      tdata[7:0] character, tlast end of line
//   out_     master     tdata[1:0] status, [8:2] expected, [15:9] entered
//
// One character word is accepted every cycle while no held result stalls it.
// A word moves from the input register through the digit logic, and an
// end-of-line word then fills the result register, which raises out_tvalid.
// The only stall is a held result: the input register then waits only if it
// holds an end-of-line word, and other characters keep flowing.
// rst_n is synchronous and active low; it clears both valid flags and the
// running per-identifier state (count, last digits, sum, check, error).

`include "snils_check_digit_validator_unit_macros.svh"

module snils_check_digit_validator_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // end of line

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [8:2] expected_check,
                                  // [15:9] entered_check
);

  // Input register.
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // Running state for the identifier being typed.
  logic [3:0] digit_count_r,   digit_count_nxt;
  logic [3:0] prev_digit_r,    prev_digit_nxt;
  logic [3:0] prev2_digit_r,   prev2_digit_nxt;
  logic [8:0] weighted_sum_r,  weighted_sum_nxt;
  logic [6:0] entered_value_r, entered_value_nxt;
  logic       format_bad_r,    format_bad_nxt;

  // Result register.
  logic                 out_v_r;
  scdv_pkg::status_t    out_status_r;
  logic [6:0]           out_expected_r;
  logic [6:0]           out_entered_r;

  logic       proc_go;
  logic       is_digit;
  logic [3:0] digit;
  logic [3:0] weight;
  logic [7:0] product;
  logic [10:0] entered_wide;
  logic [6:0] expected;

  // The processing stage moves whenever its word produces no result or the
  // result register is free or being emptied.
  assign proc_go   = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || proc_go;

  assign is_digit = (in_char_r >= scdv_pkg::CHAR_ZERO) &&
                    (in_char_r <= scdv_pkg::CHAR_NINE);
  assign digit    = 4'(in_char_r - scdv_pkg::CHAR_ZERO);
  assign weight   = scdv_pkg::SUM_DIGITS - digit_count_r;
  assign product  = {4'b0, digit} * {4'b0, weight};
  assign entered_wide = {4'b0, entered_value_r} * 11'd10 + {7'b0, digit};

  always_comb begin
    digit_count_nxt   = digit_count_r;
    prev_digit_nxt    = prev_digit_r;
    prev2_digit_nxt   = prev2_digit_r;
    weighted_sum_nxt  = weighted_sum_r;
    entered_value_nxt = entered_value_r;
    format_bad_nxt    = format_bad_r;
    if (is_digit) begin
      // Three equal kept digits in a row are a format error.
      if (digit_count_r >= scdv_pkg::REPEAT_MIN && digit == prev_digit_r &&
          digit == prev2_digit_r) begin
        format_bad_nxt = 1'b1;
      end
      if (digit_count_r < scdv_pkg::SUM_DIGITS) begin
        weighted_sum_nxt = weighted_sum_r + {1'b0, product};
      end else if (digit_count_r < scdv_pkg::SNILS_DIGITS) begin
        entered_value_nxt = entered_wide[6:0];
      end
      prev2_digit_nxt = prev_digit_r;
      prev_digit_nxt  = digit;
      if (digit_count_r < scdv_pkg::COUNT_SAT) begin
        digit_count_nxt = digit_count_r + 4'd1;
      end
    end else if (in_char_r != scdv_pkg::CHAR_DASH &&
                 in_char_r != scdv_pkg::CHAR_SPACE) begin
      format_bad_nxt = 1'b1;
    end
  end

  // A well-formed line ends on its eleventh digit or a separator, neither of
  // which touches the weighted sum, so the registered sum is already final here.
  assign expected = scdv_pkg::check_number(weighted_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
      digit_count_r   <= '0;
      prev_digit_r    <= '0;
      prev2_digit_r   <= '0;
      weighted_sum_r  <= '0;
      entered_value_r <= '0;
      format_bad_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      // A retiring end-of-line word fills the result register; otherwise it
      // holds until the receiver takes it.
      out_v_r <= (proc_go && in_last_r) || (out_v_r && !out_tready);
      if (proc_go) begin
        if (in_last_r) begin
          // Start over for the next identifier.
          digit_count_r   <= '0;
          prev_digit_r    <= '0;
          prev2_digit_r   <= '0;
          weighted_sum_r  <= '0;
          entered_value_r <= '0;
          format_bad_r    <= 1'b0;
        end else begin
          digit_count_r   <= digit_count_nxt;
          prev_digit_r    <= prev_digit_nxt;
          prev2_digit_r   <= prev2_digit_nxt;
          weighted_sum_r  <= weighted_sum_nxt;
          entered_value_r <= entered_value_nxt;
          format_bad_r    <= format_bad_nxt;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (proc_go && in_last_r) begin
      if (format_bad_nxt || digit_count_nxt != scdv_pkg::SNILS_DIGITS) begin
        out_status_r   <= scdv_pkg::STATUS_FORMAT;
        out_expected_r <= '0;
        out_entered_r  <= '0;
      end else begin
        out_status_r   <= (expected == entered_value_nxt) ?
                          scdv_pkg::STATUS_VALID : scdv_pkg::STATUS_MISMATCH;
        out_expected_r <= expected;
        out_entered_r  <= entered_value_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_entered_r, out_expected_r, out_status_r};

  // A format error reports both check numbers as zero.
  `SCDV_ASSERT_NOW(a_format_zero, clk, rst_n,
    out_v_r && out_status_r == scdv_pkg::STATUS_FORMAT,
    out_expected_r == '0 && out_entered_r == '0, "format error with nonzero checks")

  // A valid status means the computed and entered checks agree.
  `SCDV_ASSERT_NOW(a_valid_match, clk, rst_n,
    out_v_r && out_status_r == scdv_pkg::STATUS_VALID,
    out_expected_r == out_entered_r, "valid status with differing checks")

  // Retiring an end-of-line word clears the running state and fills the result register.
  `SCDV_ASSERT_NEXT(a_line_clear, clk, rst_n, proc_go && in_last_r,
    digit_count_r == '0 && !format_bad_r && weighted_sum_r == '0 && out_v_r,
    "state not cleared after end of line")

  // The digit counter never passes its saturation value.
  `SCDV_ASSERT_NOW(a_count_sat, clk, rst_n, 1'b1,
    digit_count_r <= scdv_pkg::COUNT_SAT, "digit counter past saturation")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for snils_check_digit_validator_unit: feeds identifier
// lines one character word at a time and checks every result word.
// Depends on scdv_pkg and the validator RTL only.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned WORD_TARGET = 1800;
  localparam int unsigned QUIET_START = 1500;
  localparam int unsigned DRAIN_POINT = 900;
  localparam logic [7:0]  CHAR_SLASH  = 8'h2F;   // just below '0'
  localparam logic [7:0]  CHAR_COLON  = 8'h3A;   // just above '9'

  // One result word as the validator reports it.
  typedef struct packed {
    scdv_pkg::status_t status;
    logic [6:0]        expected;
    logic [6:0]        entered;
  } snils_result_t;

  // Tracks the identifier being typed, predicts the result of each line and
  // compares the result words against those predictions in order.
  class snils_scoreboard;
    logic [3:0]    n_digits;
    logic [3:0]    last_digit;
    logic [3:0]    prior_digit;
    logic [8:0]    wsum;
    logic [6:0]    check_in;
    logic          bad;
    snils_result_t pending[$];
    int unsigned   errors;
    int unsigned   n_valid;
    int unsigned   n_mismatch;
    int unsigned   n_format;

    function new();
      clear_line();
    endfunction

    function void clear_line();
      n_digits    = '0;
      last_digit  = '0;
      prior_digit = '0;
      wsum        = '0;
      check_in    = '0;
      bad         = 1'b0;
    endfunction

    // Check number of a weighted sum. Sums of 100 and 101 fall out of the
    // modulo naturally: 100 leaves 100, which folds to zero, and 101 leaves 0.
    function logic [6:0] reduce_sum(logic [8:0] s);
      logic [8:0] rem;
      if (s < scdv_pkg::CHECK_LIMIT) begin
        return 7'(s);
      end
      rem = s % scdv_pkg::CHECK_MOD;
      return (rem == scdv_pkg::CHECK_LIMIT) ? 7'd0 : 7'(rem);
    endfunction

    // Called for every character word the validator accepts.
    function void note_char(logic [7:0] ch, logic eol);
      logic [3:0]    d;
      snils_result_t r;
      if (ch >= scdv_pkg::CHAR_ZERO && ch <= scdv_pkg::CHAR_NINE) begin
        d = 4'(ch - scdv_pkg::CHAR_ZERO);
        if (n_digits >= scdv_pkg::REPEAT_MIN && d == last_digit &&
            d == prior_digit) begin
          bad = 1'b1;
        end
        if (n_digits < scdv_pkg::SUM_DIGITS) begin
          wsum = wsum + 9'(d) * 9'(scdv_pkg::SUM_DIGITS - n_digits);
        end else if (n_digits < scdv_pkg::SNILS_DIGITS) begin
          check_in = check_in * 7'd10 + 7'(d);
        end
        prior_digit = last_digit;
        last_digit  = d;
        if (n_digits < scdv_pkg::COUNT_SAT) begin
          n_digits++;
        end
      end else if (ch != scdv_pkg::CHAR_DASH && ch != scdv_pkg::CHAR_SPACE) begin
        bad = 1'b1;
      end
      if (eol) begin
        if (bad || n_digits != scdv_pkg::SNILS_DIGITS) begin
          r.status   = scdv_pkg::STATUS_FORMAT;
          r.expected = '0;
          r.entered  = '0;
          n_format++;
        end else begin
          r.expected = reduce_sum(wsum);
          r.entered  = check_in;
          if (r.expected == r.entered) begin
            r.status = scdv_pkg::STATUS_VALID;
            n_valid++;
          end else begin
            r.status = scdv_pkg::STATUS_MISMATCH;
            n_mismatch++;
          end
        end
        pending.push_back(r);
        clear_line();
      end
    endfunction

    task report_error(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_word(logic [15:0] w);
      snils_result_t want;
      if (pending.size() == 0) begin
        report_error($sformatf("result word %h arrived with no line pending", w));
        return;
      end
      want = pending.pop_front();
      if (w[1:0] != want.status) begin
        report_error($sformatf("status %0d, predicted %0d", w[1:0], want.status));
      end
      if (w[8:2] != want.expected) begin
        report_error($sformatf("computed check %0d, predicted %0d", w[8:2], want.expected));
      end
      if (w[15:9] != want.entered) begin
        report_error($sformatf("entered check %0d, predicted %0d", w[15:9], want.entered));
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] character
  logic        in_tlast   = 1'b0;  // end of line
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [1:0] status, [8:2] expected_check,
                                   // [15:9] entered_check

  snils_scoreboard sb;
  logic [7:0]      line_buf[$];
  int unsigned     sent;
  int unsigned     cycles;
  bit              quiet;
  bit              gaps_on;

  snils_check_digit_validator_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata);
    end
  end

  // Receiver: runs of ready broken by stall bursts, no stalls in the quiet phase.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Nine weighted digits with no run of three, steered toward a target sum
  // when one is given (zero means any sum), then two check digits, correct
  // or random; triple then forces a run of three. Layout 0 is plain digits,
  // layout 1 the usual grouped form, 2 scatters dashes and spaces at random.
  function automatic void build_identifier(int unsigned target, bit good_check,
                                           bit triple, int unsigned layout);
    int unsigned d[11];
    int unsigned total;
    int unsigned tries;
    int unsigned p;
    int          i;
    logic [6:0]  chk;
    tries = 0;
    do begin
      total = 0;
      for (i = 0; i < 9; i++) begin
        do d[i] = $urandom_range(0, 9);
        while (i >= 2 && d[i] == d[i-1] && d[i] == d[i-2]);
        total += d[i] * (9 - i);
      end
      tries++;
    end while (target != 0 && total != target && tries < 4000);
    if (good_check) begin
      chk  = sb.reduce_sum(9'(total));
      d[9] = chk / 10;
      d[10] = chk % 10;
    end else begin
      d[9] = $urandom_range(0, 9);
      d[10] = $urandom_range(0, 9);
    end
    if (triple) begin
      p = $urandom_range(0, 8);
      d[p+1] = d[p];
      d[p+2] = d[p];
    end
    for (i = 0; i < 11; i++) begin
      if (layout == 2 && $urandom_range(0, 4) == 0) begin
        line_buf.push_back($urandom_range(0, 1) ?
                           scdv_pkg::CHAR_DASH : scdv_pkg::CHAR_SPACE);
      end
      line_buf.push_back(scdv_pkg::CHAR_ZERO + 8'(d[i]));
      if (layout == 1 && (i == 2 || i == 5)) begin
        line_buf.push_back(scdv_pkg::CHAR_DASH);
      end
      if (layout == 1 && i == 8) begin
        line_buf.push_back(scdv_pkg::CHAR_SPACE);
      end
    end
    if (layout == 2 && $urandom_range(0, 3) == 0) begin
      line_buf.push_back($urandom_range(0, 1) ?
                         scdv_pkg::CHAR_DASH : scdv_pkg::CHAR_SPACE);
    end
  endfunction

  // Sends the buffered line, end of line on its last word. In lines with
  // gaps enabled, idle bursts drop in before random words.
  task automatic send_line();
    int k;
    for (k = 0; k < line_buf.size(); k++) begin
      if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        in_tlast  <= 1'($urandom);
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= line_buf[k];
      in_tlast  <= (k == line_buf.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sb.note_char(line_buf[k], k == line_buf.size() - 1);
      sent++;
    end
    line_buf.delete();
  endtask

  // Holds the sender off until every predicted result has been checked.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned targets[6];
    bit          drained;
    sb = new();
    targets = '{100, 101, 201, 302, 99, 202};
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: a lone space, the two byte extremes alone, a well-formed
    // identifier steered toward a sum of 101, three equal digits and a short line.
    gaps_on = 1'b0;
    line_buf.push_back(scdv_pkg::CHAR_SPACE);
    send_line();
    line_buf.push_back(8'h00);
    send_line();
    line_buf.push_back(8'hFF);
    send_line();
    build_identifier(101, 1'b1, 1'b0, 1);
    send_line();
    line_buf = '{scdv_pkg::CHAR_ZERO + 8'd1, scdv_pkg::CHAR_ZERO + 8'd1,
                 scdv_pkg::CHAR_ZERO + 8'd1};
    send_line();
    line_buf = '{scdv_pkg::CHAR_ZERO + 8'd1, scdv_pkg::CHAR_ZERO + 8'd2};
    send_line();
    drain();

    // Random part: mostly well-formed identifiers, the rest noise.
    while (sent < WORD_TARGET) begin
      quiet   = (sent >= QUIET_START);
      gaps_on = $urandom_range(0, 1);
      if (!drained && sent >= DRAIN_POINT) begin
        drain();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_identifier(($urandom_range(0, 6) == 0) ? targets[$urandom_range(0, 5)] : 0,
                         $urandom_range(0, 9) < 7, 1'b0, $urandom_range(0, 2));
      end else if (kind < 77) begin
        build_identifier(0, 1'b1, 1'b1, $urandom_range(0, 2));
      end else if (kind < 84) begin
        build_identifier(0, 1'b1, 1'b0, $urandom_range(0, 2));
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
      end else if (kind < 92) begin
        // Random digit counts, including runs long enough to saturate the count.
        n = $urandom_range(0, 20);
        repeat (n) begin
          line_buf.push_back(scdv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 5) == 0) begin
            line_buf.push_back(scdv_pkg::CHAR_DASH);
          end
        end
        if (line_buf.size() == 0) begin
          line_buf.push_back(scdv_pkg::CHAR_SPACE);
        end
      end else begin
        // Byte soup with characters just outside the digit range.
        repeat ($urandom_range(1, 14)) begin
          case ($urandom_range(0, 3))
            0: line_buf.push_back(scdv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            1: line_buf.push_back($urandom_range(0, 1) ?
                                  scdv_pkg::CHAR_DASH : scdv_pkg::CHAR_SPACE);
            2: line_buf.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_COLON);
            default: line_buf.push_back(8'($urandom));
          endcase
        end
      end
      send_line();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d character words; results: %0d valid, %0d mismatched, %0d format errors.",
             sent, sb.n_valid, sb.n_mismatch, sb.n_format);
    $display("Random gaps and stalls on both sides, one full drain mid-run, %0d errors.",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
